/* rtl/i2cfc_pkg.sv */
// ----------------------------------------------------------------------------
// i2cfc_pkg
// Shared types, codes and the CRC-8 byte update for the I2C frame CRC block.
// ----------------------------------------------------------------------------
package i2cfc_pkg;

   localparam int ADDR_W   = 7;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 3;

   localparam int MAX_RECEIVE_DEFAULT = 32;

   // Expected length that enables the early string-end check
   localparam logic [LEN_W-1:0] STRING_END_LEN = 6'd31;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START_SEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_SEND_BYTE   = 3'd1;
   localparam logic [OP_W-1:0] OP_FINISH_SEND = 3'd2;
   localparam logic [OP_W-1:0] OP_START_RECV  = 3'd3;
   localparam logic [OP_W-1:0] OP_RECV_BYTE   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STRING_END = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_OP     = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] dev_addr;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  rx_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   byte_out;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // MSB-first CRC-8 update of one byte, unrolled over eight bit steps
   function automatic logic [BYTE_W-1:0] crc8_absorb(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] v;
      v = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (v[BYTE_W-1]) begin
            v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[BYTE_W-2:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

/* rtl/i2c_frame_crc8_framer_checker.sv */
// ----------------------------------------------------------------------------
// i2c_frame_crc8_framer_checker
// Path: a req beat passes the input register, then the result register, on
//   its way to rsp_tvalid; the CRC byte update is unrolled XOR logic.
// Throughput: one beat per cycle, sustained while rsp_tready stays high.
// Reset: synchronous, active high; clears both stages and the frame state
//   (CRC zero, no frame open).
// ----------------------------------------------------------------------------
module i2c_frame_crc8_framer_checker #(
   parameter int MAX_RECEIVE = i2cfc_pkg::MAX_RECEIVE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // dev_addr[6:0], data_byte[14:7], rx_length[20:15], zero
   input  logic [2:0]  req_tuser,   // op[2:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // byte_out[7:0]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   // Input stage: holds one accepted beat until the engine can step on it
   logic               in_valid_ff, in_valid_in;
   i2cfc_pkg::req_type in_req_ff;

   // Result stage: holds one finished result until the sink takes it
   logic               out_valid_ff, out_valid_in;
   i2cfc_pkg::rsp_type out_rsp_ff;

   i2cfc_pkg::rsp_type step_rsp;
   logic               advance;
   logic               req_fire;

   // Advance the held beat whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Unpack the beat into the request fields on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff.op        <= req_tuser;
         in_req_ff.dev_addr  <= req_tdata[6:0];
         in_req_ff.data_byte <= req_tdata[14:7];
         in_req_ff.rx_length <= req_tdata[20:15];
      end
   end

   i2cfc_engine #(
      .MAX_RECEIVE (MAX_RECEIVE)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_req_ff),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rsp_ff.byte_out;
   assign rsp_tuser  = out_rsp_ff.status;

   // A stepped beat always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("stepped beat did not reach result register");

   // A held beat is never dropped while the result side is stalled
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held beat dropped");

   // No new beat is taken while the held one cannot move
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input accepted over a stalled beat");

endmodule

/* rtl/i2cfc_engine.sv */
// ----------------------------------------------------------------------------
// i2cfc_engine
// Frame state and the single-pass step: builds the result for one beat and
// updates the CRC and frame counters when the beat advances.
// ----------------------------------------------------------------------------
module i2cfc_engine #(
   parameter int MAX_RECEIVE = i2cfc_pkg::MAX_RECEIVE_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cfc_pkg::req_type  req,
   output i2cfc_pkg::rsp_type  rsp
);

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_SEND = 2'd1;
   localparam logic [1:0] MODE_RECV = 2'd2;

   localparam logic [i2cfc_pkg::LEN_W-1:0] MaxRx = i2cfc_pkg::LEN_W'(MAX_RECEIVE);

   logic [i2cfc_pkg::BYTE_W-1:0] crc_ff,      crc_in;
   logic [1:0]                   mode_ff,     mode_in;
   logic [i2cfc_pkg::LEN_W-1:0]  rx_count_ff, rx_count_in;
   logic [i2cfc_pkg::LEN_W-1:0]  rx_exp_ff,   rx_exp_in;
   logic                         prev_zero_ff, prev_zero_in;

   logic [i2cfc_pkg::BYTE_W-1:0] addr_byte;
   logic [i2cfc_pkg::LEN_W-1:0]  len_sat;

   always_comb begin
      addr_byte    = '0;
      len_sat      = (req.rx_length > MaxRx) ? MaxRx : req.rx_length;
      crc_in       = crc_ff;
      mode_in      = mode_ff;
      rx_count_in  = rx_count_ff;
      rx_exp_in    = rx_exp_ff;
      prev_zero_in = prev_zero_ff;
      rsp.byte_out = '0;
      rsp.status   = i2cfc_pkg::ST_BAD_OP;
      unique case (req.op)
         i2cfc_pkg::OP_START_SEND: begin
            addr_byte    = {req.dev_addr, 1'b0};
            crc_in       = i2cfc_pkg::crc8_absorb('0, addr_byte);
            mode_in      = MODE_SEND;
            rsp.byte_out = addr_byte;
            rsp.status   = i2cfc_pkg::ST_OK;
         end
         i2cfc_pkg::OP_SEND_BYTE: begin
            if (mode_ff == MODE_SEND) begin
               crc_in       = i2cfc_pkg::crc8_absorb(crc_ff, req.data_byte);
               rsp.byte_out = req.data_byte;
               rsp.status   = i2cfc_pkg::ST_OK;
            end
         end
         i2cfc_pkg::OP_FINISH_SEND: begin
            if (mode_ff == MODE_SEND) begin
               rsp.byte_out = crc_ff;
               rsp.status   = i2cfc_pkg::ST_DONE;
               mode_in      = MODE_IDLE;
            end
         end
         i2cfc_pkg::OP_START_RECV: begin
            addr_byte    = {req.dev_addr, 1'b1};
            crc_in       = i2cfc_pkg::crc8_absorb('0, addr_byte);
            rx_count_in  = '0;
            prev_zero_in = 1'b0;
            rx_exp_in    = len_sat;
            rsp.byte_out = addr_byte;
            if (len_sat == '0) begin
               mode_in    = MODE_IDLE;
               rsp.status = i2cfc_pkg::ST_DONE;
            end else begin
               mode_in    = MODE_RECV;
               rsp.status = i2cfc_pkg::ST_OK;
            end
         end
         i2cfc_pkg::OP_RECV_BYTE: begin
            if (mode_ff == MODE_RECV) begin
               rsp.byte_out = req.data_byte;
               if (rx_count_ff < rx_exp_ff) begin
                  if (rx_count_ff != '0 && rx_exp_ff == i2cfc_pkg::STRING_END_LEN &&
                      prev_zero_ff && req.data_byte == crc_ff) begin
                     rsp.status = i2cfc_pkg::ST_STRING_END;
                     mode_in    = MODE_IDLE;
                  end else begin
                     crc_in       = i2cfc_pkg::crc8_absorb(crc_ff, req.data_byte);
                     prev_zero_in = (req.data_byte == '0);
                     rx_count_in  = rx_count_ff + 1'b1;
                     rsp.status   = i2cfc_pkg::ST_OK;
                  end
               end else begin
                  rsp.status = (req.data_byte == crc_ff) ? i2cfc_pkg::ST_DONE
                                                         : i2cfc_pkg::ST_MISMATCH;
                  mode_in    = MODE_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         mode_ff      <= MODE_IDLE;
         rx_count_ff  <= '0;
         rx_exp_ff    <= '0;
         prev_zero_ff <= 1'b0;
      end else if (step_en) begin
         crc_ff       <= crc_in;
         mode_ff      <= mode_in;
         rx_count_ff  <= rx_count_in;
         rx_exp_ff    <= rx_exp_in;
         prev_zero_ff <= prev_zero_in;
      end
   end

   // A receive frame never runs past its CRC byte
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_RECV) |-> (rx_count_ff <= rx_exp_ff))
      else $error("receive count passed expected length");

   // A live receive frame has a nonzero, saturated length
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_RECV) |-> (rx_exp_ff != '0 && rx_exp_ff <= MaxRx))
      else $error("expected length out of range in receive frame");

   // A rejected op leaves the frame state alone
   a_bad_op_hold: assert property (@(posedge clock) disable iff (reset)
      (step_en && rsp.status == i2cfc_pkg::ST_BAD_OP) |=>
         ($stable(crc_ff) && $stable(mode_ff) && $stable(rx_count_ff)))
      else $error("rejected op changed frame state");

   // A rejected op reports a zero byte
   a_bad_op_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.status == i2cfc_pkg::ST_BAD_OP) |-> (rsp.byte_out == '0))
      else $error("rejected op with nonzero byte");

endmodule

/* verif/tb_i2c_frame_crc8_framer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_frame_crc8_framer_checker
// Self-checking bench for the I2C frame CRC-8 framer and checker. A short
// directed pass exercises send frames, receive frames with good and bad CRC,
// zero and saturated lengths, early string end, wrong-mode ops and undefined
// ops. A long random pass then mixes well-formed frames with noise. Every
// accepted request beat feeds a cycle-free predictor, and every result beat
// is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_i2c_frame_crc8_framer_checker;

   localparam int ADDR_W   = i2cfc_pkg::ADDR_W;
   localparam int BYTE_W   = i2cfc_pkg::BYTE_W;
   localparam int LEN_W    = i2cfc_pkg::LEN_W;
   localparam int OP_W     = i2cfc_pkg::OP_W;
   localparam int STATUS_W = i2cfc_pkg::STATUS_W;

   localparam int CLK_HALF     = 5;
   localparam int RX_LIMIT     = i2cfc_pkg::MAX_RECEIVE_DEFAULT;
   localparam int RANDOM_ITEMS = 1925;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 100;

   // Op codes the block does not define
   localparam logic [OP_W-1:0] OP_FIRST_UNDEFINED = 3'd5;
   localparam logic [OP_W-1:0] OP_LAST_UNDEFINED  = 3'd7;

   typedef enum logic [1:0] {
      FRAME_IDLE,
      FRAME_SEND,
      FRAME_RECV
   } frame_mode_type;

   // -------------------------------------------------------------------------
   // Frame predictor and result store
   // -------------------------------------------------------------------------
   class crc8_frame_scoreboard;
      i2cfc_pkg::rsp_type expected_q[$];
      logic [BYTE_W-1:0]  crc;
      frame_mode_type     mode;
      logic [LEN_W-1:0]   rx_count;
      logic [LEN_W-1:0]   rx_expected;
      bit                 prev_zero;
      int                 errors;
      int                 beats_in;
      int                 beats_out;
      int                 code_seen[8];

      function new();
         crc         = '0;
         mode        = FRAME_IDLE;
         rx_count    = '0;
         rx_expected = '0;
         prev_zero   = 1'b0;
         errors      = 0;
         beats_in    = 0;
         beats_out   = 0;
         foreach (code_seen[i]) code_seen[i] = 0;
      endfunction

      // MSB-first CRC-8, one data bit per step
      function logic [BYTE_W-1:0] crc_byte(logic [BYTE_W-1:0] c,
                                           logic [BYTE_W-1:0] d);
         logic fb;
         for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ d[i];
            c  = {c[BYTE_W-2:0], 1'b0};
            if (fb) c = c ^ i2cfc_pkg::CRC_POLY;
         end
         return c;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len);
         i2cfc_pkg::rsp_type exp;
         logic [BYTE_W-1:0]  ab;
         exp.byte_out = '0;
         exp.status   = i2cfc_pkg::ST_BAD_OP;
         case (op)
            i2cfc_pkg::OP_START_SEND: begin
               ab           = {addr, 1'b0};
               crc          = crc_byte('0, ab);
               mode         = FRAME_SEND;
               exp.byte_out = ab;
               exp.status   = i2cfc_pkg::ST_OK;
            end
            i2cfc_pkg::OP_SEND_BYTE: begin
               if (mode == FRAME_SEND) begin
                  crc          = crc_byte(crc, b);
                  exp.byte_out = b;
                  exp.status   = i2cfc_pkg::ST_OK;
               end
            end
            i2cfc_pkg::OP_FINISH_SEND: begin
               if (mode == FRAME_SEND) begin
                  exp.byte_out = crc;
                  exp.status   = i2cfc_pkg::ST_DONE;
                  mode         = FRAME_IDLE;
               end
            end
            i2cfc_pkg::OP_START_RECV: begin
               ab           = {addr, 1'b1};
               crc          = crc_byte('0, ab);
               rx_count     = '0;
               prev_zero    = 1'b0;
               rx_expected  = (len > RX_LIMIT) ? LEN_W'(RX_LIMIT) : len;
               exp.byte_out = ab;
               if (rx_expected == 0) begin
                  mode       = FRAME_IDLE;
                  exp.status = i2cfc_pkg::ST_DONE;
               end else begin
                  mode       = FRAME_RECV;
                  exp.status = i2cfc_pkg::ST_OK;
               end
            end
            i2cfc_pkg::OP_RECV_BYTE: begin
               if (mode == FRAME_RECV) begin
                  exp.byte_out = b;
                  if (rx_count < rx_expected) begin
                     if (rx_count != 0 && rx_expected == i2cfc_pkg::STRING_END_LEN &&
                         prev_zero && b == crc) begin
                        exp.status = i2cfc_pkg::ST_STRING_END;
                        mode       = FRAME_IDLE;
                     end else begin
                        crc        = crc_byte(crc, b);
                        prev_zero  = (b == 0);
                        rx_count   = rx_count + 1'b1;
                        exp.status = i2cfc_pkg::ST_OK;
                     end
                  end else begin
                     exp.status = (b == crc) ? i2cfc_pkg::ST_DONE
                                             : i2cfc_pkg::ST_MISMATCH;
                     mode       = FRAME_IDLE;
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(exp);
         beats_in++;
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
      endtask

      task check_response(logic [BYTE_W-1:0] got_byte, logic [STATUS_W-1:0] got_code);
         i2cfc_pkg::rsp_type exp;
         beats_out++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result beat %0d (byte %02h code %0d) with none expected",
                                      beats_out, got_byte, got_code));
            return;
         end
         exp = expected_q.pop_front();
         code_seen[exp.status]++;
         if (got_byte !== exp.byte_out)
            report_mismatch($sformatf("result beat %0d byte_out %02h, expected %02h",
                                      beats_out, got_byte, exp.byte_out));
         if (got_code !== exp.status)
            report_mismatch($sformatf("result beat %0d code %0d, expected %0d",
                                      beats_out, got_code, exp.status));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // dev_addr[6:0], data_byte[14:7], rx_length[20:15], zero
   logic [2:0]  req_tuser  = '0;   // op[2:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // byte_out[7:0]
   logic [2:0]  rsp_tuser;         // status[2:0]

   crc8_frame_scoreboard sb;

   // Pacing controls: a steady side never idles between beats
   bit req_steady  = 1'b0;
   bit rsp_steady  = 1'b0;
   bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
   int cycle_count = 0;
   int send_frames = 0;
   int recv_frames = 0;
   int string_end_tries = 0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   i2c_frame_crc8_framer_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Kill the run if it hangs; the slowest legal run stays far below this
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int draw_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 14);
   endfunction

   // -------------------------------------------------------------------------
   // Request side: offer one beat, hold it until accepted, then note it.
   // Called and returns at a falling edge.
   // -------------------------------------------------------------------------
   task automatic offer_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len);
      int gap;
      gap = draw_gap(req_steady);
      // Drop valid only when there is a gap, so back-to-back beats stay high
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, len, b, addr};
      req_tuser  = op;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, addr, b, len);
      @(negedge clock);
   endtask

   // Wait with valid low until every predicted result has come back
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Write frame: address, zero to six pass-through bytes, then usually the CRC byte
   task automatic send_frame();
      int n;
      n = $urandom_range(0, 6);
      send_frames++;
      offer_request(i2cfc_pkg::OP_START_SEND, ADDR_W'($urandom), BYTE_W'($urandom),
                    LEN_W'($urandom));
      repeat (n)
         offer_request(i2cfc_pkg::OP_SEND_BYTE, ADDR_W'($urandom), BYTE_W'($urandom),
                       LEN_W'($urandom));
      // Leave some frames open so the next start abandons them
      if ($urandom_range(0, 11) != 0)
         offer_request(i2cfc_pkg::OP_FINISH_SEND, ADDR_W'($urandom), BYTE_W'($urandom),
                       LEN_W'($urandom));
   endtask

   // Read frame: data bytes then, usually, a CRC byte, good or corrupted. With early
   // set, plant a zero byte followed by the running CRC to end a 31-byte
   // frame at the string end.
   task automatic recv_frame(input logic [LEN_W-1:0] len, input bit crc_good,
                             input bit early);
      int                n;
      int                zero_at;
      logic [BYTE_W-1:0] b;
      n       = (len > RX_LIMIT) ? RX_LIMIT : len;
      zero_at = early ? $urandom_range(0, 28) : -2;
      recv_frames++;
      if (early) string_end_tries++;
      offer_request(i2cfc_pkg::OP_START_RECV, ADDR_W'($urandom), BYTE_W'($urandom), len);
      for (int i = 0; i < n && sb.mode == FRAME_RECV; i++) begin
         if (i == zero_at)
            b = '0;
         else if (i == zero_at + 1)
            b = sb.crc;
         else if ($urandom_range(0, 7) == 0)
            b = '0;
         else
            b = BYTE_W'($urandom);
         offer_request(i2cfc_pkg::OP_RECV_BYTE, ADDR_W'($urandom), b, LEN_W'($urandom));
      end
      if (sb.mode == FRAME_RECV && $urandom_range(0, 19) != 0) begin
         b = crc_good ? sb.crc : sb.crc ^ BYTE_W'($urandom_range(1, 255));
         offer_request(i2cfc_pkg::OP_RECV_BYTE, ADDR_W'($urandom), b, LEN_W'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: before each beat, idle for a random gap (none while steady),
   // then take the beat and check it. Honor one long hold-off request.
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         if ($urandom_range(0, 19) == 0) rsp_steady = !rsp_steady;
         gap = draw_gap(rsp_steady);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int  pick;
      int  random_start;
      bit  hold_done;
      bit  drain_done;
      logic [LEN_W-1:0] len;
      sb         = new();
      hold_done  = 1'b0;
      drain_done = 1'b0;

      // Hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // ---- Directed pass ----
      // Write frame at the lowest address with extreme data bytes
      offer_request(i2cfc_pkg::OP_START_SEND, 7'h00, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_SEND_BYTE, 7'h00, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_SEND_BYTE, 7'h7f, 8'hff, 6'h3f);
      offer_request(i2cfc_pkg::OP_FINISH_SEND, 7'h00, 8'h00, 6'h00);
      // Wrong-mode ops while idle
      offer_request(i2cfc_pkg::OP_FINISH_SEND, 7'h7f, 8'hff, 6'h3f);
      offer_request(i2cfc_pkg::OP_SEND_BYTE, 7'h7f, 8'hff, 6'h3f);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h7f, 8'hff, 6'h3f);
      // Undefined ops
      for (int u = OP_FIRST_UNDEFINED; u <= OP_LAST_UNDEFINED; u++)
         offer_request(OP_W'(u), 7'h7f, 8'hff, 6'h3f);
      // Start a write, then abandon it with a zero-length read
      offer_request(i2cfc_pkg::OP_START_SEND, 7'h7f, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_START_RECV, 7'h7f, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, 8'h12, 6'h00);
      // Saturated length, abandoned by a short read with a good CRC
      offer_request(i2cfc_pkg::OP_START_RECV, 7'h55, 8'h00, 6'h3f);
      offer_request(i2cfc_pkg::OP_START_RECV, 7'h2a, 8'h00, 6'h02);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, 8'ha5, 6'h00);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, sb.crc, 6'h00);
      // One data byte, then a corrupted CRC
      offer_request(i2cfc_pkg::OP_START_RECV, 7'h11, 8'h00, 6'h01);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, 8'h3c, 6'h00);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, ~sb.crc, 6'h00);
      // String end: zero data byte followed by the running CRC
      offer_request(i2cfc_pkg::OP_START_RECV, 7'h33, 8'h00, i2cfc_pkg::STRING_END_LEN);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, 8'h00, 6'h00);
      offer_request(i2cfc_pkg::OP_RECV_BYTE, 7'h00, sb.crc, 6'h00);

      // ---- Random pass ----
      random_start = sb.beats_in;
      while (sb.beats_in - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) req_steady = !req_steady;

         // Once: stall the receiver while the sender pushes back to back
         if (!hold_done && sb.beats_in - random_start > 600) begin
            hold_done  = 1'b1;
            hold_req   = 1'b1;
            req_steady = 1'b1;
         end
         // Once: pause until every result has come back
         if (!drain_done && sb.beats_in - random_start > 1200) begin
            drain_done = 1'b1;
            drain_results();
         end

         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            send_frame();
         end else if (pick < 74) begin
            case ($urandom_range(0, 6))
               0:       len = LEN_W'($urandom);
               1:       len = LEN_W'($urandom_range(31, 32));
               default: len = LEN_W'($urandom_range(1, 6));
            endcase
            recv_frame(len, $urandom_range(0, 3) != 0, 1'b0);
         end else if (pick < 84) begin
            recv_frame(i2cfc_pkg::STRING_END_LEN, 1'b1, 1'b1);
         end else begin
            // Noise: any op, any field values
            repeat ($urandom_range(1, 4))
               offer_request(OP_W'($urandom), ADDR_W'($urandom), BYTE_W'($urandom),
                             LEN_W'($urandom));
         end
      end

      // ---- Wind down ----
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request and %0d result beats: %0d write frames, %0d read frames,",
               sb.beats_in, sb.beats_out, send_frames, recv_frames);
      $display("  %0d string-end tries, one long stall, one drain.", string_end_tries);
      $display("Result codes: ok %0d, done %0d, crc mismatch %0d, string end %0d,",
               sb.code_seen[i2cfc_pkg::ST_OK], sb.code_seen[i2cfc_pkg::ST_DONE],
               sb.code_seen[i2cfc_pkg::ST_MISMATCH], sb.code_seen[i2cfc_pkg::ST_STRING_END]);
      $display("  bad op %0d; %0d mismatches.",
               sb.code_seen[i2cfc_pkg::ST_BAD_OP], sb.errors);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
